// ----- hw/rtl/dbfn_pkg.sv -----
package dbfn_pkg;

  localparam int unsigned BITMAP_BYTES = 512;
  localparam int unsigned BITMAP_BITS  = 4096;

  localparam int unsigned KIND_W = 3;
  localparam int unsigned PAGE_W = 12;
  localparam int unsigned NEXT_W = 13;

  localparam int unsigned ADDR_W = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BITMAP_BYTES - 1);
  localparam logic [NEXT_W-1:0] NONE_INDEX = NEXT_W'(BITMAP_BITS);

  typedef enum logic [KIND_W-1:0] {
    KIND_SET       = 3'd0,
    KIND_CLEAR     = 3'd1,
    KIND_TEST      = 3'd2,
    KIND_FIND      = 3'd3,
    KIND_CLEAR_ALL = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    RES_TEST  = 2'd0,
    RES_FOUND = 2'd1,
    RES_NONE  = 2'd2
  } res_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;     // latch request, read its start byte
    logic first;      // apply start-bit mask to the byte under test
    logic rd_next;    // advance to the next byte and read it
    logic wr_byte;    // write back set/clear result
    logic clr_step;   // zero the current byte and advance
    logic load_out;   // load the output register
    res_e res_sel;
  } dbfn_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    kind_e kind;
    logic  in_map;
    logic  byte_nz;
    logic  cur_last;
    logic  out_free;
  } dbfn_sts_t;

  // index of the lowest set bit of a byte, 0 for a zero byte
  function automatic logic [2:0] low_set_bit(input logic [7:0] v);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) begin
        n = 3'(i);
      end
    end
    return n;
  endfunction

endpackage

// ----- hw/rtl/dbfn_if.sv -----
interface dbfn_req_if;
  import dbfn_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [PAGE_W-1:0] page_index;

  modport source (output valid, output kind, output page_index, input ready);
  modport sink   (input valid, input kind, input page_index, output ready);
endinterface

interface dbfn_rsp_if;
  import dbfn_pkg::*;
  logic              valid;
  logic              ready;
  logic              bit_is_set;
  logic [NEXT_W-1:0] next_index;

  modport source (output valid, output bit_is_set, output next_index, input ready);
  modport sink   (input valid, input bit_is_set, input next_index, output ready);
endinterface

// ----- hw/rtl/dirty_bitmap_find_next.sv -----
// channel  dir  fields                       produced by
// req_i    in   kind[2:0], page_index[11:0]  every operation
// rsp_o    out  bit_is_set, next_index[12:0] test and find-next only
//
// set, clear and test: accept (byte read), then write-back or answer
// find-next: accept, then read byte by byte until a set bit or the last byte
// clear-all: accept, then one zero write per byte
// reset clears control only; the bitmap is undefined until a clear-all
// a result waits in the output register while the next request is accepted;
// if that register is still full when a new result is ready, the block holds
module dirty_bitmap_find_next
  import dbfn_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  dbfn_req_if.sink          req_i,
  dbfn_rsp_if.source        rsp_o
);

  dbfn_cmd_t cmd;
  dbfn_sts_t sts;

  // sequencing: accept, read-modify-write, byte scan, clear sweep
  dbfn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_kind_i  (req_i.kind),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // bitmap memory, byte pointer, masking and output register
  dbfn_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .kind_i       (req_i.kind),
    .page_index_i (req_i.page_index),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (rsp_o.ready),
    .out_valid_o  (rsp_o.valid),
    .bit_is_set_o (rsp_o.bit_is_set),
    .next_index_o (rsp_o.next_index)
  );

endmodule

// ----- hw/rtl/dbfn_dp.sv -----
module dbfn_dp
  import dbfn_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [PAGE_W-1:0] page_index_i,
  input  dbfn_cmd_t         cmd_i,
  output dbfn_sts_t         sts_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic              bit_is_set_o,
  output logic [NEXT_W-1:0] next_index_o
);

  logic [7:0]        mem [BITMAP_BYTES];
  logic [7:0]        rd_q;
  logic [KIND_W-1:0] kind_q;
  logic [PAGE_W-1:0] page_q;
  logic [ADDR_W-1:0] cur_q, cur_d;
  logic              out_valid_q;
  logic              bit_q;
  logic [NEXT_W-1:0] next_q;

  logic              in_map_in, in_map;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [7:0]        wr_data;
  logic [7:0]        bit_mask;
  logic [7:0]        test_byte;
  logic              out_free;

  assign in_map_in = 32'(page_index_i[PAGE_W-1:3]) < BITMAP_BYTES;
  assign in_map    = 32'(page_q[PAGE_W-1:3]) < BITMAP_BYTES;
  assign bit_mask  = 8'd1 << page_q[2:0];
  assign test_byte = cmd_i.first ? (rd_q & (8'hFF << page_q[2:0])) : rd_q;
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    cur_d   = cur_q;
    rd_en   = 1'b0;
    rd_addr = cur_q + ADDR_W'(1);
    if (cmd_i.accept) begin
      if (kind_e'(kind_i) == KIND_CLEAR_ALL) begin
        cur_d = '0;
      end else begin
        cur_d = ADDR_W'(page_index_i[PAGE_W-1:3]);
      end
      rd_addr = ADDR_W'(page_index_i[PAGE_W-1:3]);
      rd_en   = in_map_in;
    end else if (cmd_i.rd_next || cmd_i.clr_step) begin
      cur_d = cur_q + ADDR_W'(1);
      rd_en = cmd_i.rd_next;
    end
  end

  always_comb begin
    wr_en   = cmd_i.wr_byte || cmd_i.clr_step;
    wr_data = 8'h00;
    if (cmd_i.wr_byte) begin
      if (kind_e'(kind_q) == KIND_SET) begin
        wr_data = rd_q | bit_mask;
      end else begin
        wr_data = rd_q & ~bit_mask;
      end
    end
  end

  // bitmap storage, no reset: cleared by the clear-all sweep
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cur_q] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= kind_i;
      page_q <= page_index_i;
    end
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      case (cmd_i.res_sel)
        RES_TEST: begin
          bit_q  <= in_map & |(rd_q & bit_mask);
          next_q <= '0;
        end
        RES_FOUND: begin
          bit_q  <= 1'b0;
          next_q <= NEXT_W'({cur_q, low_set_bit(test_byte)});
        end
        default: begin
          bit_q  <= 1'b0;
          next_q <= NONE_INDEX;
        end
      endcase
    end
  end

  assign sts_o.kind     = kind_e'(kind_q);
  assign sts_o.in_map   = in_map;
  assign sts_o.byte_nz  = |test_byte;
  assign sts_o.cur_last = cur_q == LAST_ADDR;
  assign sts_o.out_free = out_free;

  assign out_valid_o  = out_valid_q;
  assign bit_is_set_o = bit_q;
  assign next_index_o = next_q;

endmodule

// ----- hw/rtl/dbfn_ctrl.sv -----
module dbfn_ctrl
  import dbfn_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic [KIND_W-1:0] req_kind_i,
  output logic              req_ready_o,
  input  dbfn_sts_t         sts_i,
  output dbfn_cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RMW  = 4'b0010,
    S_SCAN = 4'b0100,
    S_CLR  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.res_sel = RES_NONE;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          case (kind_e'(req_kind_i))
            KIND_SET, KIND_CLEAR, KIND_TEST, KIND_FIND: state_d = S_RMW;
            KIND_CLEAR_ALL:                             state_d = S_CLR;
            default:                                    state_d = S_IDLE;
          endcase
        end
      end
      S_RMW: begin
        case (sts_i.kind)
          KIND_SET, KIND_CLEAR: begin
            cmd_o.wr_byte = sts_i.in_map;
            state_d       = S_IDLE;
          end
          KIND_TEST: begin
            cmd_o.res_sel = RES_TEST;
            if (sts_i.out_free) begin
              cmd_o.load_out = 1'b1;
              state_d        = S_IDLE;
            end
          end
          KIND_FIND: begin
            cmd_o.first = 1'b1;
            if (!sts_i.in_map || sts_i.byte_nz || sts_i.cur_last) begin
              cmd_o.res_sel = (sts_i.in_map && sts_i.byte_nz) ? RES_FOUND : RES_NONE;
              if (sts_i.out_free) begin
                cmd_o.load_out = 1'b1;
                state_d        = S_IDLE;
              end
            end else begin
              cmd_o.rd_next = 1'b1;
              state_d       = S_SCAN;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_SCAN: begin
        if (sts_i.byte_nz || sts_i.cur_last) begin
          cmd_o.res_sel = sts_i.byte_nz ? RES_FOUND : RES_NONE;
          if (sts_i.out_free) begin
            cmd_o.load_out = 1'b1;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.rd_next = 1'b1;
        end
      end
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.cur_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import dbfn_pkg::*;

  // clock period and run bounds
  localparam int unsigned CLK_PERIOD  = 8;
  localparam int unsigned RESET_CYCLES = 5;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned TARGET_REQS = 1100;

  // kinds that the block ignores
  localparam logic [KIND_W-1:0] KIND_RSVD_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_RSVD_LAST  = 3'd7;

  // extreme page numbers
  localparam logic [PAGE_W-1:0] PAGE_FIRST = '0;
  localparam logic [PAGE_W-1:0] PAGE_LAST  = '1;

  // one answer on the response channel
  typedef struct packed {
    logic              bit_is_set;
    logic [NEXT_W-1:0] next_index;
  } answer_t;

  // one row of the directed table; known marks a hand-typed answer
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PAGE_W-1:0] page;
    logic              known;
    answer_t           answer;
  } dir_row_t;

  localparam answer_t NO_ANSWER = '{1'b0, '0};

  logic clk;
  logic rst_n;

  dbfn_req_if req_if ();
  dbfn_rsp_if rsp_if ();

  dirty_bitmap_find_next DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // shadow copy of the bitmap, and answers still owed by the block
  bit [7:0] shadow_map [BITMAP_BYTES];
  answer_t  pending_answers [$];

  int unsigned mismatch_count;
  int unsigned requests_sent;
  int unsigned burst_left;
  logic [PAGE_W-1:0] hot_base;

  // directed table: clear first, since the bitmap is undefined after reset
  dir_row_t directed_rows [26] = '{
    '{KIND_CLEAR_ALL, PAGE_FIRST, 1'b0, NO_ANSWER},
    // empty map: find has nothing, test reads zero at both ends
    '{KIND_FIND,      PAGE_FIRST, 1'b1, '{1'b0, NONE_INDEX}},
    '{KIND_TEST,      PAGE_FIRST, 1'b1, '{1'b0, 13'd0}},
    '{KIND_TEST,      PAGE_LAST,  1'b1, '{1'b0, 13'd0}},
    // top page only
    '{KIND_SET,       PAGE_LAST,  1'b0, NO_ANSWER},
    '{KIND_FIND,      PAGE_FIRST, 1'b1, '{1'b0, 13'd4095}},
    '{KIND_TEST,      PAGE_LAST,  1'b1, '{1'b1, 13'd0}},
    // page 0 set: start at 0 sees it, start at 1 masks it off
    '{KIND_SET,       PAGE_FIRST, 1'b0, NO_ANSWER},
    '{KIND_FIND,      PAGE_FIRST, 1'b1, '{1'b0, 13'd0}},
    '{KIND_FIND,      12'd1,      1'b1, '{1'b0, 13'd4095}},
    // hit in the second byte, start exactly on the bit and past it
    '{KIND_SET,       12'd9,      1'b0, NO_ANSWER},
    '{KIND_FIND,      12'd1,      1'b1, '{1'b0, 13'd9}},
    '{KIND_FIND,      12'd9,      1'b1, '{1'b0, 13'd9}},
    '{KIND_FIND,      12'd10,     1'b1, '{1'b0, 13'd4095}},
    // drop the top page: scan runs off the end
    '{KIND_CLEAR,     PAGE_LAST,  1'b0, NO_ANSWER},
    '{KIND_FIND,      12'd10,     1'b1, '{1'b0, NONE_INDEX}},
    '{KIND_TEST,      12'd9,      1'b1, '{1'b1, 13'd0}},
    // ignored kinds change nothing and answer nothing
    '{KIND_RSVD_FIRST, 12'd123,   1'b0, NO_ANSWER},
    '{KIND_RSVD_LAST,  12'd2730,  1'b0, NO_ANSWER},
    // hit inside the start byte above the mask
    '{KIND_SET,       12'd7,      1'b0, NO_ANSWER},
    '{KIND_FIND,      12'd1,      1'b0, NO_ANSWER},
    '{KIND_CLEAR,     12'd9,      1'b0, NO_ANSWER},
    '{KIND_TEST,      12'd9,      1'b0, NO_ANSWER},
    '{KIND_SET,       12'd2048,   1'b0, NO_ANSWER},
    '{KIND_FIND,      12'd8,      1'b0, NO_ANSWER},
    // clear-all wipes everything
    '{KIND_CLEAR_ALL, 12'd1365,   1'b0, NO_ANSWER}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // reset, once, at the start
  initial begin
    rst_n = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // known values on every input from time zero
  initial begin
    req_if.valid      = 1'b0;
    req_if.kind       = '0;
    req_if.page_index = '0;
    rsp_if.ready      = 1'b0;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // lowest set page at or above start, or the map size when there is none
  function automatic logic [NEXT_W-1:0] first_set_from(input int unsigned start);
    int unsigned b;
    bit [7:0]    v;
    for (b = start / 8; b < BITMAP_BYTES; b++) begin
      v = shadow_map[b];
      // first byte: bits below the start do not count
      if (b == start / 8) begin
        v = v & (8'hFF << (start % 8));
      end
      for (int i = 0; i < 8; i++) begin
        if (v[i]) begin
          return NEXT_W'(b * 8 + i);
        end
      end
    end
    return NEXT_W'(BITMAP_BITS);
  endfunction

  // update the shadow map for an accepted request and queue what it owes
  task automatic track_request(input logic [KIND_W-1:0] k, input logic [PAGE_W-1:0] p,
                               input logic known, input answer_t typed);
    int unsigned byte_ix;
    int unsigned bit_ix;
    logic        in_map;
    answer_t     ans;
    byte_ix = p / 8;
    bit_ix  = p % 8;
    in_map  = byte_ix < BITMAP_BYTES;
    ans     = NO_ANSWER;
    case (k)
      KIND_SET: begin
        if (in_map) shadow_map[byte_ix][bit_ix] = 1'b1;
      end
      KIND_CLEAR: begin
        if (in_map) shadow_map[byte_ix][bit_ix] = 1'b0;
      end
      KIND_TEST: begin
        ans.bit_is_set = in_map ? shadow_map[byte_ix][bit_ix] : 1'b0;
        pending_answers.push_back(known ? typed : ans);
      end
      KIND_FIND: begin
        ans.next_index = first_set_from(p);
        pending_answers.push_back(known ? typed : ans);
      end
      KIND_CLEAR_ALL: begin
        foreach (shadow_map[i]) shadow_map[i] = '0;
      end
      default: begin
        // reserved kinds are dropped by the block
      end
    endcase
  endtask

  // drive one request; the sender runs in bursts with random gaps between them
  task automatic send_request(input logic [KIND_W-1:0] k, input logic [PAGE_W-1:0] p,
                              input logic known, input answer_t typed);
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      case ($urandom_range(0, 3))
        0: gap = 0;
        1: gap = $urandom_range(20, 60);
        default: gap = $urandom_range(1, 8);
      endcase
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req_if.valid      <= 1'b1;
    req_if.kind       <= k;
    req_if.page_index <= p;
    // wait for the handshake, sampled at the rising edge
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    track_request(k, p, known, typed);
    if (k <= KIND_CLEAR_ALL) requests_sent++;
  endtask

  // hold the sender off until the block owes nothing
  task automatic drain_answers();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
  endtask

  // page mostly near a moving hot spot, some extremes, some anywhere
  function automatic logic [PAGE_W-1:0] pick_page();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return hot_base + PAGE_W'($urandom_range(0, 47));
    if (r < 75) begin
      case ($urandom_range(0, 3))
        0: return PAGE_FIRST;
        1: return PAGE_LAST;
        2: return {9'($urandom), 3'b000};
        default: return {9'($urandom), 3'b111};
      endcase
    end
    return PAGE_W'($urandom);
  endfunction

  // one random request with a weighted kind
  task automatic send_random_request();
    int unsigned r;
    logic [KIND_W-1:0] k;
    r = $urandom_range(0, 199);
    if (r < 70) k = KIND_SET;
    else if (r < 95) k = KIND_CLEAR;
    else if (r < 135) k = KIND_TEST;
    else if (r < 185) k = KIND_FIND;
    else if (r < 188) k = KIND_CLEAR_ALL;
    else k = KIND_RSVD_FIRST + KIND_W'($urandom_range(0, 2));
    send_request(k, pick_page(), 1'b0, NO_ANSWER);
  endtask

  // flush loop as software runs it: find, maybe clear the hit, find past it
  task automatic walk_dirty_pages();
    int unsigned start;
    logic [NEXT_W-1:0] hit;
    start = hot_base;
    for (int n = 0; n < 8; n++) begin
      send_request(KIND_FIND, PAGE_W'(start), 1'b0, NO_ANSWER);
      hit = first_set_from(start);
      if (hit >= NONE_INDEX) break;
      if ($urandom_range(0, 1)) begin
        send_request(KIND_CLEAR, PAGE_W'(hit), 1'b0, NO_ANSWER);
      end
      start = hit + 1;
      if (start >= BITMAP_BITS) break;
    end
  endtask

  // receiver: stretches of always-ready, light and heavy stalls
  initial begin
    int unsigned mode;
    logic [31:0] stall_word;
    @(posedge rst_n);
    forever begin
      mode       = $urandom_range(0, 2);
      stall_word = $urandom;
      repeat ($urandom_range(16, 96)) begin
        @(negedge clk);
        case (mode)
          0: rsp_if.ready <= 1'b1;
          1: rsp_if.ready <= stall_word[0] | stall_word[3];
          default: rsp_if.ready <= stall_word[0] & stall_word[5];
        endcase
        stall_word = {stall_word[30:0], stall_word[31]};
      end
    end
  end

  // response checker: every answer against the oldest one owed
  always @(posedge clk) begin
    answer_t owed;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("unexpected answer bit_is_set=%0d next_index=%0d",
                                  rsp_if.bit_is_set, rsp_if.next_index));
      end else begin
        owed = pending_answers.pop_front();
        if (rsp_if.bit_is_set !== owed.bit_is_set) begin
          report_mismatch($sformatf("bit_is_set got %0d want %0d",
                                    rsp_if.bit_is_set, owed.bit_is_set));
        end
        if (rsp_if.next_index !== owed.next_index) begin
          report_mismatch($sformatf("next_index got %0d want %0d",
                                    rsp_if.next_index, owed.next_index));
        end
      end
    end
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("dirty_bitmap_find_next verification failed");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int unsigned next_pause;
    mismatch_count = 0;
    requests_sent  = 0;
    burst_left     = 0;
    hot_base       = '0;
    foreach (shadow_map[i]) shadow_map[i] = '0;
    @(posedge rst_n);

    // directed part
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].kind, directed_rows[i].page,
                   directed_rows[i].known, directed_rows[i].answer);
    end

    // random part: fills, flush walks and single requests around a hot spot
    next_pause = $urandom_range(200, 400);
    while (requests_sent < TARGET_REQS) begin
      if ($urandom_range(0, 49) == 0) hot_base = PAGE_W'($urandom);
      case ($urandom_range(0, 9))
        0, 1: walk_dirty_pages();
        2: begin
          repeat ($urandom_range(4, 16)) begin
            send_request(KIND_SET, hot_base + PAGE_W'($urandom_range(0, 47)),
                         1'b0, NO_ANSWER);
          end
        end
        default: send_random_request();
      endcase
      // pause with nothing in flight now and then
      if (requests_sent >= next_pause) begin
        drain_answers();
        next_pause = requests_sent + $urandom_range(150, 350);
      end
    end

    // let everything owed come back, then let a trailing clear-all finish
    drain_answers();
    repeat (BITMAP_BYTES + 32) @(posedge clk);
    if (pending_answers.size() != 0) begin
      report_mismatch($sformatf("%0d answers never arrived", pending_answers.size()));
    end

    if (mismatch_count == 0) begin
      $display("dirty_bitmap_find_next verification clean");
    end else begin
      $display("dirty_bitmap_find_next verification failed");
    end
    $finish;
  end

endmodule
